/* design/arfd_pkg.sv */
// ----------------------------------------------------------------------------
// arfd_pkg
// Shared types, constants and helpers for the animation rle frame decoder.
// ----------------------------------------------------------------------------
package arfd_pkg;

  localparam int MAX_DIMENSION   = 4096;
  localparam int PIXEL_BYTES     = 3;
  localparam int MIN_FRAME_BYTES = 8;
  localparam int HEADER_LINES_BIT = 3;

  localparam logic [7:0] CODE_LINE_END = 8'hFF;
  localparam logic [7:0] CODE_SKIP     = 8'h00;

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DEPTH_IS_24  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        depth_is_24;
  } cfg_t;

  typedef struct packed {
    logic [23:0] frame_size;
    logic        frame_start;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        outside_frame;
    logic [6:0]  run_count;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] column;
    logic [15:0] row;
  } result_t;

  // register value clipped to the largest supported dimension
  function automatic logic [15:0] eff_dim(input logic [12:0] v);
    logic [15:0] v16;
    v16 = {3'b000, v};
    return (v16 > 16'(MAX_DIMENSION)) ? 16'(MAX_DIMENSION) : v16;
  endfunction

endpackage

/* design/arfd_apb_regs.sv */
// ----------------------------------------------------------------------------
// arfd_apb_regs
// Configuration registers behind a simple apb-style port.
// ----------------------------------------------------------------------------
module arfd_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [arfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output arfd_pkg::cfg_t                 cfg
);
  import arfd_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 13'd640;
      cfg.frame_height <= 13'd480;
      cfg.depth_is_24  <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[12:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[12:0];
        REG_DEPTH_IS_24:  cfg.depth_is_24  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = {19'd0, cfg.frame_width};
      REG_FRAME_HEIGHT: prdata = {19'd0, cfg.frame_height};
      REG_DEPTH_IS_24:  prdata = {31'd0, cfg.depth_is_24};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* design/arfd_in_stage.sv */
// ----------------------------------------------------------------------------
// arfd_in_stage
// Input register in front of the parser; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module arfd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  arfd_pkg::in_item_t in_item,
  output logic               held_valid,
  output arfd_pkg::in_item_t held_item,
  input  logic               take
);
  import arfd_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

/* design/arfd_parser.sv */
// ----------------------------------------------------------------------------
// arfd_parser
// Frame parser state machine: one byte per step, at most one pixel write.
// ----------------------------------------------------------------------------
module arfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  arfd_pkg::cfg_t     cfg,
  input  logic               take,
  input  arfd_pkg::in_item_t item,
  output logic               res_valid,
  output arfd_pkg::result_t  res
);
  import arfd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SIZE, PH_HEAD, PH_START, PH_COUNT,
    PH_LSKIP, PH_CODE, PH_SKIPC, PH_RUNC, PH_LITC
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  fbc, fbc_next;
  logic [15:0] header_word, header_word_next;
  logic [15:0] lines_left, lines_left_next;
  logic [15:0] current_row, current_row_next;
  logic [15:0] current_column, current_column_next; // column plus one
  logic [6:0]  pixels_left, pixels_left_next;
  logic [15:0] colour_bytes, colour_bytes_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic        pend_valid, pend_valid_next;
  logic [7:0]  pend_blue, pend_blue_next;

  logic [15:0] eff_w, eff_h;
  logic [7:0]  b;
  logic        go;
  logic [16:0] col_sum;
  logic [8:0]  run_len;

  assign eff_w = eff_dim(cfg.frame_width);
  assign eff_h = eff_dim(cfg.frame_height);
  assign b     = item.data_byte;

  function automatic result_t make_put(input logic [15:0] row, input logic [15:0] pos1,
                                       input logic [6:0] count, input logic [7:0] blue,
                                       input logic [15:0] colour, input logic [15:0] w,
                                       input logic [15:0] h);
    result_t     r;
    logic [15:0] col;
    col             = (pos1 != 16'd0) ? pos1 - 16'd1 : 16'd0;
    r.row           = row;
    r.column        = col;
    r.red           = colour[15:8];
    r.green         = colour[7:0];
    r.blue          = blue;
    r.run_count     = count;
    r.outside_frame = (row >= h) || (pos1 == 16'd0) ||
                      (({1'b0, col} + 17'(count)) > {1'b0, w});
    return r;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [8:0] d);
    logic [16:0] s;
    s = {1'b0, a} + 17'(d);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  always_comb begin
    phase_next          = phase;
    fbc_next            = fbc;
    header_word_next    = header_word;
    lines_left_next     = lines_left;
    current_row_next    = current_row;
    current_column_next = current_column;
    pixels_left_next    = pixels_left;
    colour_bytes_next   = colour_bytes;
    bytes_left_next     = bytes_left;
    pend_valid_next     = pend_valid;
    pend_blue_next      = pend_blue;
    res_valid           = 1'b0;
    res                 = '0;
    go                  = 1'b0;
    col_sum             = '0;
    run_len             = '0;

    if (take) begin
      go = 1'b1;
      // last pixel of a 128-pixel run goes out ahead of this byte's work
      if (pend_valid) begin
        res             = make_put(current_row, current_column - 16'd1, 7'd1, pend_blue,
                                   colour_bytes, eff_w, eff_h);
        res_valid       = 1'b1;
        pend_valid_next = 1'b0;
      end

      if (item.frame_start) begin
        bytes_left_next     = item.frame_size;
        fbc_next            = 2'd0;
        header_word_next    = 16'd0;
        lines_left_next     = 16'd0;
        current_row_next    = 16'd0;
        current_column_next = 16'd0;
        pixels_left_next    = 7'd0;
        colour_bytes_next   = 16'd0;
        if (item.frame_size <= 24'(MIN_FRAME_BYTES) || !cfg.depth_is_24) begin
          phase_next = PH_IDLE;
          go         = 1'b0;
        end else begin
          phase_next = PH_SIZE;
        end
      end

      if (go && (phase_next == PH_IDLE || bytes_left_next == 24'd0)) begin
        phase_next = PH_IDLE;
        go         = 1'b0;
      end

      if (go) begin
        case (phase_next)
          PH_SIZE: begin
            if (fbc_next == 2'd3) phase_next = PH_HEAD;
            fbc_next = fbc_next + 2'd1;
          end
          PH_HEAD: begin
            header_word_next = {header_word_next[7:0], b};
            if (fbc_next == 2'd1) begin
              fbc_next = 2'd0;
              if (header_word_next[HEADER_LINES_BIT]) begin
                phase_next = PH_START;
              end else begin
                current_row_next = 16'd0;
                lines_left_next  = eff_h;
                phase_next       = (eff_h != 16'd0) ? PH_LSKIP : PH_IDLE;
              end
            end else begin
              fbc_next = fbc_next + 2'd1;
            end
          end
          PH_START: begin
            if (fbc_next == 2'd0)      current_row_next = {b, 8'd0};
            else if (fbc_next == 2'd1) current_row_next = {current_row_next[15:8], b};
            if (fbc_next == 2'd3) phase_next = PH_COUNT;
            fbc_next = fbc_next + 2'd1;
          end
          PH_COUNT: begin
            if (fbc_next == 2'd0)      lines_left_next = {b, 8'd0};
            else if (fbc_next == 2'd1) lines_left_next = {lines_left_next[15:8], b};
            if (fbc_next == 2'd3) begin
              phase_next = (lines_left_next != 16'd0) ? PH_LSKIP : PH_IDLE;
            end
            fbc_next = fbc_next + 2'd1;
          end
          PH_LSKIP: begin
            current_column_next = {8'd0, b};
            phase_next          = PH_CODE;
          end
          PH_CODE: begin
            fbc_next = 2'd0;
            if (b == CODE_LINE_END) begin
              current_row_next = (current_row_next == 16'hFFFF) ? 16'hFFFF
                                                                : current_row_next + 16'd1;
              lines_left_next  = lines_left_next - 16'd1;
              phase_next       = (lines_left_next != 16'd0) ? PH_LSKIP : PH_IDLE;
            end else if (b == CODE_SKIP) begin
              phase_next = PH_SKIPC;
            end else if (b[7]) begin
              // a count of zero here means 128
              pixels_left_next = 7'(8'd0 - b);
              phase_next       = PH_RUNC;
            end else begin
              pixels_left_next = b[6:0];
              phase_next       = PH_LITC;
            end
          end
          PH_SKIPC: begin
            if (b == 8'd0) begin
              current_column_next = (current_column_next != 16'd0) ?
                                    current_column_next - 16'd1 : 16'd0;
            end else begin
              col_sum             = {1'b0, current_column_next} + 17'(b) - 17'd1;
              current_column_next = col_sum[16] ? 16'hFFFF : col_sum[15:0];
            end
            phase_next = PH_CODE;
          end
          PH_RUNC, PH_LITC: begin
            if (fbc_next == 2'd0) begin
              colour_bytes_next = {b, 8'd0};
              fbc_next          = 2'd1;
            end else if (fbc_next == 2'd1) begin
              colour_bytes_next = {colour_bytes_next[15:8], b};
              fbc_next          = 2'd2;
            end else begin
              fbc_next  = 2'd0;
              res_valid = 1'b1;
              if (phase_next == PH_RUNC) begin
                run_len = (pixels_left_next == 7'd0) ? 9'd128 : {2'b00, pixels_left_next};
                res = make_put(current_row_next, current_column_next,
                               (pixels_left_next == 7'd0) ? 7'd127 : pixels_left_next,
                               b, colour_bytes_next, eff_w, eff_h);
                current_column_next = sat_add(current_column_next, run_len);
                if (pixels_left_next == 7'd0) begin
                  pend_valid_next = 1'b1;
                  pend_blue_next  = b;
                end
                phase_next = PH_CODE;
              end else begin
                res = make_put(current_row_next, current_column_next, 7'd1, b,
                               colour_bytes_next, eff_w, eff_h);
                current_column_next = sat_add(current_column_next, 9'd1);
                pixels_left_next    = pixels_left_next - 7'd1;
                if (pixels_left_next == 7'd0) phase_next = PH_CODE;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase

        bytes_left_next = bytes_left_next - 24'd1;
        if (bytes_left_next == 24'd0) phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      fbc            <= 2'd0;
      header_word    <= 16'd0;
      lines_left     <= 16'd0;
      current_row    <= 16'd0;
      current_column <= 16'd0;
      pixels_left    <= 7'd0;
      colour_bytes   <= 16'd0;
      bytes_left     <= 24'd0;
      pend_valid     <= 1'b0;
      pend_blue      <= 8'd0;
    end else begin
      phase          <= phase_next;
      fbc            <= fbc_next;
      header_word    <= header_word_next;
      lines_left     <= lines_left_next;
      current_row    <= current_row_next;
      current_column <= current_column_next;
      pixels_left    <= pixels_left_next;
      colour_bytes   <= colour_bytes_next;
      bytes_left     <= bytes_left_next;
      pend_valid     <= pend_valid_next;
      pend_blue      <= pend_blue_next;
    end
  end

  // a held run tail only waits behind a code byte or a finished frame
  a_pend_phase: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (phase == PH_CODE || phase == PH_IDLE))
    else $error("run tail held in unexpected phase");

  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    (take && pend_valid) |=> !pend_valid)
    else $error("run tail not released");

  a_colour_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RUNC || phase == PH_LITC) |-> fbc != 2'd3)
    else $error("colour byte index out of range");

  a_result_on_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> take)
    else $error("result without an item");

endmodule

/* design/arfd_out_buf.sv */
// ----------------------------------------------------------------------------
// arfd_out_buf
// Two-entry result buffer; keeps the parser moving while the sink stalls, until both entries are full.
// ----------------------------------------------------------------------------
module arfd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arfd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output arfd_pkg::result_t out_data
);
  import arfd_pkg::*;

  result_t    entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

endmodule

/* design/animation_rle_frame_decoder.sv */
// ----------------------------------------------------------------------------
// animation_rle_frame_decoder
// Decoder for 24-bit animation rle frames, one byte in, pixel writes out.
// ----------------------------------------------------------------------------
// The decoder takes one frame byte per clock cycle while its two-entry result
// buffer has space, which keeps that rate while the result side stalls for a
// while; a byte waits in the input register, passes through the combinational
// parser, and the write it completes is registered in the result buffer. Each
// literal pixel or run gives one write; a run of 128 pixels gives a write of
// 127 followed by a single-pixel write that leaves with the next byte taken.
// Configuration writes are meant for idle periods between frames.
module animation_rle_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // byte stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // data_byte[7:0], frame_size[31:8]
  input  logic                            s_tuser,  // frame_start
  // pixel writes out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,  // row, column, red, green, blue,
                                                    // run_count, zero pad
  output logic                            m_tuser   // outside_frame
);
  import arfd_pkg::*;

  cfg_t     cfg;
  in_item_t in_item, held_item;
  logic     held_valid, take, space, res_valid;
  result_t  res, out_data;

  assign in_item.data_byte   = s_tdata[7:0];
  assign in_item.frame_size  = s_tdata[31:8];
  assign in_item.frame_start = s_tuser;

  arfd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  assign take = held_valid && space;

  arfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  arfd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {1'b0, out_data.run_count, out_data.blue, out_data.green,
                    out_data.red, out_data.column, out_data.row};
  assign m_tuser = out_data.outside_frame;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the animation rle frame decoder.
// Frames are streamed a byte at a time, under random stalls on both sides
// except in the last two segments. A bit-accurate decoder model predicts every
// pixel write, and each write that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arfd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 120;

  typedef enum logic [3:0] {
    PARSE_IDLE, PARSE_SIZE, PARSE_HEADER, PARSE_START_LINE, PARSE_LINE_COUNT,
    PARSE_LINE_SKIP, PARSE_CODE, PARSE_SKIP, PARSE_RUN, PARSE_LITERAL
  } parse_phase_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata  = '0;  // data_byte[7:0], frame_size[31:8]
  logic                  s_tuser  = 1'b0; // frame_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;  // row, column, red, green, blue, run_count, pad
  logic                  m_tuser;  // outside_frame

  animation_rle_frame_decoder u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  initial begin
    forever #5 clk = ~clk;
  end

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // decoder model state
  parse_phase_t phase;
  int unsigned  field_pos;
  logic [15:0]  header_word, lines_left, cur_row, cur_col1, colour;
  logic [6:0]   pixels_left;
  logic [23:0]  bytes_left;
  logic         tail_due;
  logic [7:0]   tail_blue;
  logic [12:0]  cfg_width, cfg_height;
  logic         cfg_depth24;

  result_t      expected_writes[$];
  logic [7:0]   frame_buf[$];

  int unsigned seg_width[SEGMENTS]  = '{12, 1, 8191, 40, 4096, 7};
  int unsigned seg_height[SEGMENTS] = '{6, 1, 8191, 4, 2, 4097};
  int unsigned seg_depth[SEGMENTS]  = '{1, 1, 1, 0, 1, 1};

  function automatic int unsigned dim_limit(logic [12:0] v);
    return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
  endfunction

  function automatic logic [15:0] sat_u16(int unsigned v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void reset_decoder();
    cfg_width   = 13'd640;
    cfg_height  = 13'd480;
    cfg_depth24 = 1'b1;
    phase       = PARSE_IDLE;
    field_pos   = 0;
    header_word = '0;
    lines_left  = '0;
    cur_row     = '0;
    cur_col1    = '0;
    colour      = '0;
    pixels_left = '0;
    bytes_left  = '0;
    tail_due    = 1'b0;
    tail_blue   = '0;
  endfunction

  // pos1 is the column plus one, so 0 stands for column -1
  function automatic void push_write(int unsigned pos1, int unsigned count, logic [7:0] blue);
    result_t     w;
    int unsigned col;
    col             = (pos1 != 0) ? pos1 - 1 : 0;
    w.row           = cur_row;
    w.column        = col[15:0];
    w.red           = colour[15:8];
    w.green         = colour[7:0];
    w.blue          = blue;
    w.run_count     = count[6:0];
    w.outside_frame = (cur_row >= dim_limit(cfg_height)) || (pos1 == 0) ||
                      (col + count > dim_limit(cfg_width));
    expected_writes.push_back(w);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic start, logic [23:0] size);
    logic [7:0]  neg;
    int unsigned run_len;
    // last pixel of a 128 run leaves with whatever item comes next
    if (tail_due) begin
      push_write(32'(cur_col1) - 1, 1, tail_blue);
      tail_due = 1'b0;
    end
    if (start) begin
      bytes_left  = size;
      field_pos   = 0;
      header_word = '0;
      lines_left  = '0;
      cur_row     = '0;
      cur_col1    = '0;
      pixels_left = '0;
      colour      = '0;
      if (size <= MIN_FRAME_BYTES || !cfg_depth24) begin
        phase = PARSE_IDLE;
        return;
      end
      phase = PARSE_SIZE;
    end
    if (phase == PARSE_IDLE || bytes_left == 0) begin
      phase = PARSE_IDLE;
      return;
    end
    case (phase)
      PARSE_SIZE: begin
        field_pos++;
        if (field_pos >= 4) begin
          phase     = PARSE_HEADER;
          field_pos = 0;
        end
      end
      PARSE_HEADER: begin
        header_word = {header_word[7:0], b};
        field_pos++;
        if (field_pos >= 2) begin
          field_pos = 0;
          if (header_word[HEADER_LINES_BIT]) begin
            phase = PARSE_START_LINE;
          end else begin
            cur_row    = '0;
            lines_left = 16'(dim_limit(cfg_height));
            phase      = (lines_left != 0) ? PARSE_LINE_SKIP : PARSE_IDLE;
          end
        end
      end
      PARSE_START_LINE: begin
        if (field_pos == 0) cur_row = {b, 8'h00};
        else if (field_pos == 1) cur_row[7:0] = b;
        field_pos++;
        if (field_pos >= 4) begin
          phase     = PARSE_LINE_COUNT;
          field_pos = 0;
        end
      end
      PARSE_LINE_COUNT: begin
        if (field_pos == 0) lines_left = {b, 8'h00};
        else if (field_pos == 1) lines_left[7:0] = b;
        field_pos++;
        if (field_pos >= 4) begin
          field_pos = 0;
          phase     = (lines_left != 0) ? PARSE_LINE_SKIP : PARSE_IDLE;
        end
      end
      PARSE_LINE_SKIP: begin
        cur_col1 = {8'h00, b};
        phase    = PARSE_CODE;
      end
      PARSE_CODE: begin
        field_pos = 0;
        if (b == CODE_LINE_END) begin
          cur_row    = sat_u16(32'(cur_row) + 1);
          lines_left = lines_left - 16'd1;
          phase      = (lines_left != 0) ? PARSE_LINE_SKIP : PARSE_IDLE;
        end else if (b == CODE_SKIP) begin
          phase = PARSE_SKIP;
        end else if (b[7]) begin
          neg         = 8'h00 - b;
          pixels_left = neg[6:0];  // zero stands for 128
          phase       = PARSE_RUN;
        end else begin
          pixels_left = b[6:0];
          phase       = PARSE_LITERAL;
        end
      end
      PARSE_SKIP: begin
        if (b == 8'h00) cur_col1 = (cur_col1 != 0) ? cur_col1 - 16'd1 : 16'd0;
        else cur_col1 = sat_u16(32'(cur_col1) + b - 1);
        phase = PARSE_CODE;
      end
      PARSE_RUN, PARSE_LITERAL: begin
        if (field_pos == 0) begin
          colour    = {b, 8'h00};
          field_pos = 1;
        end else if (field_pos == 1) begin
          colour[7:0] = b;
          field_pos   = 2;
        end else begin
          field_pos = 0;
          if (phase == PARSE_RUN) begin
            run_len = (pixels_left != 0) ? pixels_left : 128;
            push_write(cur_col1, (run_len > 127) ? 127 : run_len, b);
            cur_col1 = sat_u16(32'(cur_col1) + run_len);
            if (run_len > 127) begin
              tail_due  = 1'b1;
              tail_blue = b;
            end
            phase = PARSE_CODE;
          end else begin
            push_write(cur_col1, 1, b);
            cur_col1    = sat_u16(32'(cur_col1) + 1);
            pixels_left = pixels_left - 7'd1;
            if (pixels_left == 0) phase = PARSE_CODE;
          end
        end
      end
      default: ;
    endcase
    bytes_left = bytes_left - 24'd1;
    if (bytes_left == 0) phase = PARSE_IDLE;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic start, input logic [23:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {size, b};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    decode_byte(b, start, size);
  endtask

  task automatic send_frame(input logic [23:0] declared, input int len, input logic with_start);
    for (int i = 0; i < len; i++)
      send_byte(frame_buf[i], with_start && (i == 0), (i == 0) ? declared : 24'($urandom));
  endtask

  // closes any open frame, flushes a run tail and waits for the block to go quiet
  task automatic settle();
    send_byte(8'h00, 1'b1, 24'd0);
    s_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  cfg_width   = value[12:0];
      REG_FRAME_HEIGHT: cfg_height  = value[12:0];
      REG_DEPTH_IS_24:  cfg_depth24 = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned d);
    settle();
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
    apb_write(REG_DEPTH_IS_24, d);
  endtask

  // -------------------------------------------------------- frame building

  function automatic logic [7:0] skip_value();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'($urandom_range(2, 20));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_line();
    int n_codes, kind, n_pix;
    frame_buf.push_back(skip_value());
    n_codes = $urandom_range(0, 4);
    repeat (n_codes) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        n_pix = ($urandom_range(15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 4);
        frame_buf.push_back(8'(n_pix));
        repeat (PIXEL_BYTES * n_pix) frame_buf.push_back(8'($urandom));
      end else if (kind < 80) begin
        if ($urandom_range(7) == 0) frame_buf.push_back(8'h80);
        else if ($urandom_range(1) == 0) frame_buf.push_back(8'(256 - $urandom_range(2, 6)));
        else frame_buf.push_back(8'($urandom_range(8'h81, 8'hFE)));
        repeat (PIXEL_BYTES) frame_buf.push_back(8'($urandom));
      end else begin
        frame_buf.push_back(CODE_SKIP);
        frame_buf.push_back(skip_value());
      end
    end
    frame_buf.push_back(CODE_LINE_END);
  endfunction

  function automatic void build_frame();
    logic        with_lines;
    logic [7:0]  header_lo;
    logic [15:0] first_row, n_count;
    int          n_lines;
    frame_buf.delete();
    repeat (4) frame_buf.push_back(8'($urandom));
    with_lines                  = ($urandom_range(9) < 7);
    header_lo                   = 8'($urandom);
    header_lo[HEADER_LINES_BIT] = with_lines;
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(header_lo);
    n_lines = $urandom_range(1, 3);
    if (with_lines) begin
      case ($urandom_range(7))
        0: first_row = 16'(dim_limit(cfg_height)) - 16'($urandom_range(0, 1));
        1: first_row = 16'hFFFE + 16'($urandom_range(1));
        2: first_row = 16'($urandom);
        default: first_row = 16'($urandom_range(0, 5));
      endcase
      case ($urandom_range(9))
        0: n_count = 16'h0000;
        1: n_count = 16'($urandom);
        default: n_count = 16'($urandom_range(1, 3));
      endcase
      frame_buf.push_back(first_row[15:8]);
      frame_buf.push_back(first_row[7:0]);
      repeat (2) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(n_count[15:8]);
      frame_buf.push_back(n_count[7:0]);
      repeat (2) frame_buf.push_back(8'($urandom));
      // sometimes one line more than announced
      if (n_count != 0 && n_count <= 3) n_lines = n_count + $urandom_range(0, 1);
    end
    repeat (n_lines) add_line();
  endfunction

  task automatic random_frame();
    int          kind, len;
    logic [23:0] declared;
    kind = $urandom_range(99);
    if (kind < 80) begin
      build_frame();
      len      = frame_buf.size();
      declared = 24'(len);
      case ($urandom_range(9))
        0: declared = 24'($urandom_range(9, len));        // frame ends early
        1: len = $urandom_range(1, len);                  // cut off, next start abandons it
        2: declared = 24'(len + $urandom_range(1, 20));   // left open
        default: ;
      endcase
      send_frame(declared, len, 1'b1);
    end else begin
      frame_buf.delete();
      repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
      if (kind < 90) send_frame(24'($urandom_range(0, MIN_FRAME_BYTES)), frame_buf.size(), 1'b1);
      else send_frame(24'($urandom), frame_buf.size(), 1'($urandom));
    end
  endtask

  // ------------------------------------------------------------ test tasks

  // column -1, a run of 128 with its tail, skip of zero, literal, line end,
  // lines used up, an oversized frame cut by a restart, then a tiny frame
  task automatic test_directed();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h1A, 8'h00, 8'h08,
                  8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                  8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, CODE_SKIP, 8'h00,
                  8'h01, 8'h00, 8'hFF, 8'h00, CODE_LINE_END};
    send_frame(24'hFFFFFF, frame_buf.size(), 1'b1);
    frame_buf = '{8'h12, 8'h34};
    send_frame(24'(MIN_FRAME_BYTES), frame_buf.size(), 1'b1);
  endtask

  // drives the column and the row into their saturation value of 65535
  task automatic test_coordinate_limits();
    frame_buf = '{8'h00, 8'h00, 8'h02, 8'h30, 8'h00, 8'h08,
                  8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00,
                  8'hFF};
    repeat (258) begin
      frame_buf.push_back(CODE_SKIP);
      frame_buf.push_back(8'hFF);
    end
    frame_buf = {frame_buf, 8'hFE, 8'h11, 8'h22, 8'h33, CODE_LINE_END,
                 8'h01, 8'h01, 8'h44, 8'h55, 8'h66, CODE_LINE_END,
                 8'h00, CODE_SKIP, 8'h00, 8'h01, 8'h77, 8'h88, 8'h99, CODE_LINE_END};
    send_frame(24'(frame_buf.size()), frame_buf.size(), 1'b1);
  endtask

  task automatic test_random_frames(input int n_items);
    int first;
    first = items_sent;
    while (items_sent - first < n_items) random_frame();
  endtask

  // ------------------------------------------------------------ checking

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_writes
    result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.row           = m_tdata[15:0];
      got.column        = m_tdata[31:16];
      got.red           = m_tdata[39:32];
      got.green         = m_tdata[47:40];
      got.blue          = m_tdata[55:48];
      got.run_count     = m_tdata[62:56];
      got.outside_frame = m_tuser;
      if (expected_writes.size() == 0) begin
        mismatches++;
        $display("%0t unexpected pixel write: expected none, actual row %0d column %0d",
                 $time, got.row, got.column);
      end else begin
        want = expected_writes.pop_front();
        check_field("row", want.row, got.row);
        check_field("column", want.column, got.column);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("run_count", want.run_count, got.run_count);
        check_field("outside_frame", want.outside_frame, got.outside_frame);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 73;
    test_directed();
    test_coordinate_limits();
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 73;
        recv_idle_pct = 38;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(seg_width[seg], seg_height[seg], seg_depth[seg]);
      test_random_frames(SEG_ITEMS);
    end
    settle();
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
